FILE: rtl/qrs_pkg.sv
// qrs_pkg: shared constants and the root kind codes of the quadratic root solver
// used by the solver top level, its cells and its port checker; no dependencies
package qrs_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COEF_W        = 32;
    localparam int VAL_W         = 32;
    localparam int DEN_W         = COEF_W + 1;

    localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        KIND_REPEATED = 2'd0,
        KIND_TWO_REAL = 2'd1,
        KIND_COMPLEX  = 2'd2,
        KIND_A_ZERO   = 2'd3
    } root_kind_t;

endpackage

FILE: rtl/qrs_sqrt_cell.sv
// qrs_sqrt_cell: one digit step of a restoring square root, registered
// one instance per root bit forms the square root chain; uses qrs_pkg
module qrs_sqrt_cell import qrs_pkg::*;
#(
    parameter int QW     = 49,
    parameter int RW     = 2 * QW,
    parameter int SIDE_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid_in,
    input  logic [QW:0]       rem_in,
    input  logic [QW-1:0]     root_in,
    input  logic [RW-1:0]     rad_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              valid_out,
    output logic [QW:0]       rem_out,
    output logic [QW-1:0]     root_out,
    output logic [RW-1:0]     rad_out,
    output logic [SIDE_W-1:0] side_out
);

    logic              valid_reg;
    logic [QW:0]       rem_reg;
    logic [QW:0]       rem_next;
    logic [QW-1:0]     root_reg;
    logic [QW-1:0]     root_next;
    logic [RW-1:0]     rad_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [QW+1:0]     cur;
    logic [QW+1:0]     trial;
    logic [QW+2:0]     diff;
    logic              ge;

    // bring down the next two radicand bits and try root*4+1
    assign cur       = {rem_in[QW-1:0], rad_in[RW-1:RW-2]};
    assign trial     = {root_in, 2'b01};
    assign diff      = {1'b0, cur} - {1'b0, trial};
    assign ge        = !diff[QW+2];
    assign rem_next  = ge ? diff[QW:0] : cur[QW:0];
    assign root_next = {root_in[QW-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && valid_in)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= {rad_in[RW-3:0], 2'b00};
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign rad_out   = rad_reg;
    assign side_out  = side_reg;

endmodule

FILE: rtl/qrs_div_cell.sv
// qrs_div_cell: one quotient bit of two restoring divisions sharing a divisor
// one instance per quotient bit forms the divider chain; uses qrs_pkg
module qrs_div_cell import qrs_pkg::*;
#(
    parameter int NW     = 50,
    parameter int SIDE_W = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid_in,
    input  logic [DEN_W-1:0]  den_in,
    input  logic [DEN_W-1:0]  rem1_in,
    input  logic [DEN_W-1:0]  rem2_in,
    input  logic [NW-1:0]     num1_in,
    input  logic [NW-1:0]     num2_in,
    input  logic [NW-1:0]     quo1_in,
    input  logic [NW-1:0]     quo2_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              valid_out,
    output logic [DEN_W-1:0]  den_out,
    output logic [DEN_W-1:0]  rem1_out,
    output logic [DEN_W-1:0]  rem2_out,
    output logic [NW-1:0]     num1_out,
    output logic [NW-1:0]     num2_out,
    output logic [NW-1:0]     quo1_out,
    output logic [NW-1:0]     quo2_out,
    output logic [SIDE_W-1:0] side_out
);

    logic              valid_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem1_reg;
    logic [DEN_W-1:0]  rem2_reg;
    logic [NW-1:0]     num1_reg;
    logic [NW-1:0]     num2_reg;
    logic [NW-1:0]     quo1_reg;
    logic [NW-1:0]     quo2_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [DEN_W:0]    cur1;
    logic [DEN_W:0]    cur2;
    logic [DEN_W+1:0]  diff1;
    logic [DEN_W+1:0]  diff2;
    logic              ge1;
    logic              ge2;

    assign cur1  = {rem1_in, num1_in[NW-1]};
    assign cur2  = {rem2_in, num2_in[NW-1]};
    assign diff1 = {1'b0, cur1} - {2'b00, den_in};
    assign diff2 = {1'b0, cur2} - {2'b00, den_in};
    assign ge1   = !diff1[DEN_W+1];
    assign ge2   = !diff2[DEN_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && valid_in)
        begin
            den_reg  <= den_in;
            rem1_reg <= ge1 ? diff1[DEN_W-1:0] : cur1[DEN_W-1:0];
            rem2_reg <= ge2 ? diff2[DEN_W-1:0] : cur2[DEN_W-1:0];
            num1_reg <= {num1_in[NW-2:0], 1'b0};
            num2_reg <= {num2_in[NW-2:0], 1'b0};
            quo1_reg <= {quo1_in[NW-2:0], ge1};
            quo2_reg <= {quo2_in[NW-2:0], ge2};
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign den_out   = den_reg;
    assign rem1_out  = rem1_reg;
    assign rem2_out  = rem2_reg;
    assign num1_out  = num1_reg;
    assign num2_out  = num2_reg;
    assign quo1_out  = quo1_reg;
    assign quo2_out  = quo2_reg;
    assign side_out  = side_reg;

endmodule

FILE: rtl/quadratic_root_solver.sv
// stages 1 to 3, the square root chain, stages S and T, the divider chain, output register
// throughput: one item per cycle unless stalled; set by the square root chain
// (33 + FRAC_BITS cells) and the divider chain (34 + FRAC_BITS cells), each cell one root or
// quotient bit; the whole pipeline stalls only while a result waits in the output register
// and the last divider cell is full; rst_n clears all valid flags, payload is not reset
module quadratic_root_solver import qrs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [COEF_W-1:0] coef_a,
    input  logic signed [COEF_W-1:0] coef_b,
    input  logic signed [COEF_W-1:0] coef_c,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              root_kind,
    output logic signed [VAL_W-1:0] first_value,
    output logic signed [VAL_W-1:0] second_value,
    output logic                    saturated
);

    localparam int RW    = 66 + 2 * FRAC_BITS;
    localparam int QW    = RW / 2;
    localparam int NW    = 33 + FRAC_BITS;
    localparam int SW    = 35 + FRAC_BITS;
    localparam int NWD   = SW - 1;
    localparam int SQS   = 2 + 1 + NW + DEN_W;
    localparam int DVS   = 4;

    logic en;
    logic held;

    // stage 1: products
    logic                     s1_valid_reg;
    logic [63:0]              s1_b2_reg;
    logic signed [63:0]       s1_p_reg;
    logic signed [COEF_W-1:0] s1_a_reg;
    logic signed [COEF_W-1:0] s1_b_reg;
    logic [COEF_W-1:0]        b_mag;
    logic [63:0]              b2_next;
    logic signed [63:0]       p_next;

    // stage 2: discriminant and -b scaled
    logic                     s2_valid_reg;
    logic signed [65:0]       s2_d_reg;
    logic signed [65:0]       d_next;
    logic signed [NW-1:0]     s2_n_reg;
    logic signed [NW-1:0]     n_next;
    logic signed [COEF_W-1:0] s2_a_reg;

    // stage 3: radicand, kind, divisor
    logic                     s3_valid_reg;
    logic [RW-1:0]            s3_rad_reg;
    logic [SQS-1:0]           s3_side_reg;
    logic [65:0]              d_abs;
    logic [COEF_W-1:0]        a_mag;
    root_kind_t               kind_next;

    // square root chain
    logic                     sq_valid [QW+1];
    logic [QW:0]              sq_rem   [QW+1];
    logic [QW-1:0]            sq_root  [QW+1];
    logic [RW-1:0]            sq_rad   [QW+1];
    logic [SQS-1:0]           sq_side  [QW+1];

    // stage S: numerators
    root_kind_t               sq_kind;
    logic                     sq_asign;
    logic signed [NW-1:0]     sq_n;
    logic [DEN_W-1:0]         sq_den;
    logic signed [SW-1:0]     n_ext;
    logic signed [SW-1:0]     q_ext;
    logic signed [SW-1:0]     sum1_next;
    logic signed [SW-1:0]     sum2_next;
    logic                     ss_valid_reg;
    logic signed [SW-1:0]     ss_sum1_reg;
    logic signed [SW-1:0]     ss_sum2_reg;
    root_kind_t               ss_kind_reg;
    logic                     ss_asign_reg;
    logic [DEN_W-1:0]         ss_den_reg;

    // stage T: magnitudes and quotient signs
    logic                     st_valid_reg;
    logic [NWD-1:0]           st_mag1_reg;
    logic [NWD-1:0]           st_mag2_reg;
    logic [DVS-1:0]           st_side_reg;
    logic [DEN_W-1:0]         st_den_reg;
    logic signed [SW-1:0]     abs1;
    logic signed [SW-1:0]     abs2;

    // divider chain
    logic                     dv_valid [NWD+1];
    logic [DEN_W-1:0]         dv_den   [NWD+1];
    logic [DEN_W-1:0]         dv_rem1  [NWD+1];
    logic [DEN_W-1:0]         dv_rem2  [NWD+1];
    logic [NWD-1:0]           dv_num1  [NWD+1];
    logic [NWD-1:0]           dv_num2  [NWD+1];
    logic [NWD-1:0]           dv_quo1  [NWD+1];
    logic [NWD-1:0]           dv_quo2  [NWD+1];
    logic [DVS-1:0]           dv_side  [NWD+1];

    // output
    logic                     out_valid_reg;
    root_kind_t               kind_reg;
    logic [VAL_W-1:0]         first_reg;
    logic [VAL_W-1:0]         second_reg;
    logic                     sat_reg;
    root_kind_t               dv_kind;
    logic [VAL_W:0]           res1;
    logic [VAL_W:0]           res2;

    // returns {clipped, value}
    function automatic logic [VAL_W:0] sat_value(input logic [NWD-1:0] q, input logic neg);
        logic hi_pos;
        logic hi_neg;
        hi_pos = |q[NWD-1:VAL_W-1];
        hi_neg = (|q[NWD-1:VAL_W]) || (q[VAL_W-1] && (|q[VAL_W-2:0]));
        if (neg)
        begin
            sat_value = hi_neg ? {1'b1, VAL_MIN} : {1'b0, VAL_W'(-q[VAL_W-1:0])};
        end
        else
        begin
            sat_value = hi_pos ? {1'b1, VAL_MAX} : {1'b0, q[VAL_W-1:0]};
        end
    endfunction

    assign held     = out_valid_reg && !out_ready;
    assign en       = !held || !dv_valid[NWD];
    assign in_ready = en;

    // ---------------- stage 1
    assign b_mag   = coef_b[COEF_W-1] ? COEF_W'(-coef_b) : coef_b;
    assign b2_next = b_mag * b_mag;
    assign p_next  = coef_a * coef_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            ss_valid_reg <= 1'b0;
            st_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            ss_valid_reg <= sq_valid[QW];
            st_valid_reg <= ss_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            s1_b2_reg <= b2_next;
            s1_p_reg  <= p_next;
            s1_a_reg  <= coef_a;
            s1_b_reg  <= coef_b;
        end
    end

    // ---------------- stage 2
    assign d_next = $signed({2'b00, s1_b2_reg}) - ($signed({{2{s1_p_reg[63]}}, s1_p_reg}) <<< 2);
    assign n_next = -$signed({s1_b_reg[COEF_W-1], s1_b_reg, {FRAC_BITS{1'b0}}});

    always_ff @(posedge clk)
    begin
        if (en && s1_valid_reg)
        begin
            s2_d_reg <= d_next;
            s2_n_reg <= n_next;
            s2_a_reg <= s1_a_reg;
        end
    end

    // ---------------- stage 3
    assign d_abs = s2_d_reg[65] ? 66'(-s2_d_reg) : 66'(s2_d_reg);
    assign a_mag = s2_a_reg[COEF_W-1] ? COEF_W'(-s2_a_reg) : s2_a_reg;

    always_comb
    begin
        priority if (s2_a_reg == '0)
        begin
            kind_next = KIND_A_ZERO;
        end
        else if (s2_d_reg == '0)
        begin
            kind_next = KIND_REPEATED;
        end
        else if (s2_d_reg[65])
        begin
            kind_next = KIND_COMPLEX;
        end
        else
        begin
            kind_next = KIND_TWO_REAL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && s2_valid_reg)
        begin
            s3_rad_reg  <= {1'b0, d_abs[64:0], {(2 * FRAC_BITS){1'b0}}};
            s3_side_reg <= {kind_next, s2_a_reg[COEF_W-1], s2_n_reg, a_mag, 1'b0};
        end
    end

    // ---------------- square root chain
    assign sq_valid[0] = s3_valid_reg;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_rad[0]   = s3_rad_reg;
    assign sq_side[0]  = s3_side_reg;

    for (genvar i = 0; i < QW; i++)
    begin : g_sqrt
        qrs_sqrt_cell #(
            .QW     (QW),
            .RW     (RW),
            .SIDE_W (SQS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (sq_valid[i]),
            .rem_in    (sq_rem[i]),
            .root_in   (sq_root[i]),
            .rad_in    (sq_rad[i]),
            .side_in   (sq_side[i]),
            .valid_out (sq_valid[i+1]),
            .rem_out   (sq_rem[i+1]),
            .root_out  (sq_root[i+1]),
            .rad_out   (sq_rad[i+1]),
            .side_out  (sq_side[i+1])
        );
    end

    // ---------------- stage S
    assign sq_kind  = root_kind_t'(sq_side[QW][SQS-1:SQS-2]);
    assign sq_asign = sq_side[QW][SQS-3];
    assign sq_n     = $signed(sq_side[QW][SQS-4:DEN_W]);
    assign sq_den   = sq_side[QW][DEN_W-1:0];
    assign n_ext    = SW'(sq_n);
    assign q_ext    = $signed({2'b00, sq_root[QW]});

    always_comb
    begin
        unique case (sq_kind)
            KIND_REPEATED:
            begin
                sum1_next = n_ext;
                sum2_next = n_ext;
            end
            KIND_TWO_REAL:
            begin
                sum1_next = n_ext + q_ext;
                sum2_next = n_ext - q_ext;
            end
            KIND_COMPLEX:
            begin
                sum1_next = n_ext;
                sum2_next = q_ext;
            end
            default:
            begin
                sum1_next = '0;
                sum2_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en && sq_valid[QW])
        begin
            ss_sum1_reg  <= sum1_next;
            ss_sum2_reg  <= sum2_next;
            ss_kind_reg  <= sq_kind;
            ss_asign_reg <= sq_asign;
            ss_den_reg   <= sq_den;
        end
    end

    // ---------------- stage T
    assign abs1 = ss_sum1_reg[SW-1] ? -ss_sum1_reg : ss_sum1_reg;
    assign abs2 = ss_sum2_reg[SW-1] ? -ss_sum2_reg : ss_sum2_reg;

    always_ff @(posedge clk)
    begin
        if (en && ss_valid_reg)
        begin
            st_mag1_reg <= abs1[NWD-1:0];
            st_mag2_reg <= abs2[NWD-1:0];
            st_side_reg <= {ss_kind_reg, ss_sum1_reg[SW-1] ^ ss_asign_reg,
                            ss_sum2_reg[SW-1] ^ ss_asign_reg};
            st_den_reg  <= ss_den_reg;
        end
    end

    // ---------------- divider chain
    assign dv_valid[0] = st_valid_reg;
    assign dv_den[0]   = st_den_reg;
    assign dv_rem1[0]  = '0;
    assign dv_rem2[0]  = '0;
    assign dv_num1[0]  = st_mag1_reg;
    assign dv_num2[0]  = st_mag2_reg;
    assign dv_quo1[0]  = '0;
    assign dv_quo2[0]  = '0;
    assign dv_side[0]  = st_side_reg;

    for (genvar j = 0; j < NWD; j++)
    begin : g_div
        qrs_div_cell #(
            .NW     (NWD),
            .SIDE_W (DVS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (dv_valid[j]),
            .den_in    (dv_den[j]),
            .rem1_in   (dv_rem1[j]),
            .rem2_in   (dv_rem2[j]),
            .num1_in   (dv_num1[j]),
            .num2_in   (dv_num2[j]),
            .quo1_in   (dv_quo1[j]),
            .quo2_in   (dv_quo2[j]),
            .side_in   (dv_side[j]),
            .valid_out (dv_valid[j+1]),
            .den_out   (dv_den[j+1]),
            .rem1_out  (dv_rem1[j+1]),
            .rem2_out  (dv_rem2[j+1]),
            .num1_out  (dv_num1[j+1]),
            .num2_out  (dv_num2[j+1]),
            .quo1_out  (dv_quo1[j+1]),
            .quo2_out  (dv_quo2[j+1]),
            .side_out  (dv_side[j+1])
        );
    end

    // ---------------- saturation and output register
    assign dv_kind = root_kind_t'(dv_side[NWD][3:2]);
    assign res1    = sat_value(dv_quo1[NWD], dv_side[NWD][1]);
    assign res2    = sat_value(dv_quo2[NWD], dv_side[NWD][0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!held)
        begin
            out_valid_reg <= dv_valid[NWD];
        end
    end

    always_ff @(posedge clk)
    begin
        if (!held && dv_valid[NWD])
        begin
            kind_reg <= dv_kind;
            if (dv_kind == KIND_A_ZERO)
            begin
                first_reg  <= '0;
                second_reg <= '0;
                sat_reg    <= 1'b0;
            end
            else
            begin
                first_reg  <= res1[VAL_W-1:0];
                second_reg <= res2[VAL_W-1:0];
                sat_reg    <= res1[VAL_W] | res2[VAL_W];
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign root_kind    = kind_reg;
    assign first_value  = $signed(first_reg);
    assign second_value = $signed(second_reg);
    assign saturated    = sat_reg;

endmodule

FILE: rtl/qrs_checker.sv
// qrs_checker: port-level checks of the quadratic root solver, bound to its top level
// depends on qrs_pkg and quadratic_root_solver
module qrs_checker import qrs_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic signed [COEF_W-1:0] coef_a,
    input logic signed [COEF_W-1:0] coef_b,
    input logic signed [COEF_W-1:0] coef_c,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [1:0]               root_kind,
    input logic signed [VAL_W-1:0]  first_value,
    input logic signed [VAL_W-1:0]  second_value,
    input logic                     saturated
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(root_kind)
            && $stable(first_value) && $stable(second_value) && $stable(saturated))
        else $error("result item changed while stalled");

    // nothing waiting at the output means the pipe can always move
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_zero_lead: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && root_kind == KIND_A_ZERO |->
            first_value == '0 && second_value == '0 && !saturated)
        else $error("zero leading coefficient result not cleared");

    a_repeated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && root_kind == KIND_REPEATED |-> first_value == second_value)
        else $error("repeated root values differ");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (.*);
